// ----- hdl/afc_pkg.sv -----
// Package for the affine cipher symbol block: widths, payload structs,
// register index codes and the sequencer state type. No dependencies.
package afc_pkg;

  localparam int SYMBOL_BITS = 8;                 // symbol index width, 5..16
  localparam int KEY_W       = 8;                 // key_a and key_b width
  localparam int ALPH_W      = 9;                 // alphabet_size width
  localparam int CFG_W       = ALPH_W;            // widest register
  localparam int RES_W       = SYMBOL_BITS;       // residue width
  localparam int MOD_W       = SYMBOL_BITS + 1;   // modulus width, holds 2^SYMBOL_BITS
  localparam int CMP_W       = (ALPH_W > MOD_W) ? ALPH_W : MOD_W;
  localparam int STEP_MAX    = (KEY_W > MOD_W) ? KEY_W : MOD_W;
  localparam int CNT_W       = $clog2(STEP_MAX);

  localparam logic [MOD_W-1:0] MOD_MAX = MOD_W'(1) << SYMBOL_BITS;

  localparam logic [1:0] REG_KEY_A    = 2'd0;
  localparam logic [1:0] REG_KEY_B    = 2'd1;
  localparam logic [1:0] REG_ALPHABET = 2'd2;

  localparam logic KIND_ENCRYPT = 1'b0;
  localparam logic KIND_DECRYPT = 1'b1;

  typedef struct packed {
    logic             kind;
    logic [RES_W-1:0] symbol;
  } afc_in_t;

  typedef struct packed {
    logic [RES_W-1:0] coded_symbol;
    logic             key_error;
  } afc_out_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_REDUCE,
    ST_ROUTE,
    ST_EUC,
    ST_DIV,
    ST_UPD,
    ST_MUL,
    ST_FIN
  } afc_state_t;

endpackage

// ----- hdl/affine_cipher_symbol.sv -----
// Affine cipher on one alphabet symbol index, bit-serial datapath.
// Depends on afc_pkg (widths, payload structs, register codes, state type).
//
//  channel | ports                          | direction | transfer when
//  --------+--------------------------------+-----------+----------------------
//  input   | in_valid, in_ready, in_data    | in        | in_valid & in_ready
//  result  | out_valid, out_ready, out_data | out       | out_valid & out_ready
//  config  | cfg_valid, cfg_ready,          | in        | cfg_valid & cfg_ready
//          | cfg_index, cfg_data            |           |
//
// Encrypt runs from transfer to result through these states in order: REDUCE
// reduces key_a and key_b mod m one bit a cycle, ROUTE routes, MUL runs the
// shift-and-add modular multiplier and FIN writes the result register; after
// that write the sequencer is idle and can take the next transfer. Decrypt
// with a held inverse takes the same path; with a held key error it skips the
// multiplier. The first decrypt after a key_a or alphabet_size write adds the
// extended Euclid inverse: each quotient step is a restoring division in
// ST_DIV framed by ST_EUC and ST_UPD (at most about a dozen steps), and a final
// ST_EUC and a return to ST_ROUTE close it out. The inverse is then held until
// the next such write. Reset is synchronous and active low; it restores the
// keys to 1/0/26, drops the held inverse and empties the result register. A
// stalled result register does not block the next input transfer; only the
// final write of the following item waits for it. Configuration is taken only
// while the sequencer is idle, and in_ready drops while a configuration write
// is offered.
module affine_cipher_symbol (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  afc_pkg::afc_in_t               in_data,
  output logic                           out_valid,
  input  logic                           out_ready,
  output afc_pkg::afc_out_t              out_data,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [1:0]                     cfg_index,
  input  logic [afc_pkg::CFG_W-1:0]      cfg_data
);

  localparam int RES_W = afc_pkg::RES_W;
  localparam int MOD_W = afc_pkg::MOD_W;
  localparam int KEY_W = afc_pkg::KEY_W;
  localparam int CNT_W = afc_pkg::CNT_W;

  // Shift one bit into a partial remainder and subtract the modulus once.
  function automatic logic [MOD_W-1:0] red_step(input logic [MOD_W-1:0] r,
                                                input logic b,
                                                input logic [MOD_W-1:0] m);
    logic [MOD_W:0] s;
    s = {r, b};
    if (s >= {1'b0, m}) s = s - {1'b0, m};
    return s[MOD_W-1:0];
  endfunction

  // One Horner step of a modular product: 2*acc + add, mod m.
  function automatic logic [RES_W-1:0] dbl_add(input logic [RES_W-1:0] acc,
                                               input logic [RES_W-1:0] add,
                                               input logic [MOD_W-1:0] m);
    logic [MOD_W-1:0] s;
    s = {acc, 1'b0};
    if (s >= m) s = s - m;
    s = s + MOD_W'(add);
    if (s >= m) s = s - m;
    return s[RES_W-1:0];
  endfunction

  function automatic logic [RES_W-1:0] add_mod(input logic [RES_W-1:0] a,
                                               input logic [RES_W-1:0] b,
                                               input logic [MOD_W-1:0] m);
    logic [MOD_W-1:0] s;
    s = MOD_W'(a) + MOD_W'(b);
    if (s >= m) s = s - m;
    return s[RES_W-1:0];
  endfunction

  function automatic logic [RES_W-1:0] sub_mod(input logic [RES_W-1:0] a,
                                               input logic [RES_W-1:0] b,
                                               input logic [MOD_W-1:0] m);
    logic [MOD_W-1:0] s;
    if (a >= b) s = MOD_W'(a) - MOD_W'(b);
    else        s = MOD_W'(a) + m - MOD_W'(b);
    return s[RES_W-1:0];
  endfunction

  // Configuration registers
  logic [KEY_W-1:0]           key_a_r, key_b_r;
  logic [afc_pkg::ALPH_W-1:0] alph_r;

  // Sequencer
  afc_pkg::afc_state_t state_r, state_nxt;
  logic [CNT_W-1:0]    cnt_r;

  // Item and key reduction lanes
  logic             kind_r;
  logic [RES_W-1:0] x_r;
  logic [KEY_W-1:0] a_sh_r, b_sh_r;
  logic [MOD_W-1:0] ra_r, rb_r;

  // Euclid and bit-serial divider
  logic [MOD_W-1:0] r0_r, r1_r, rem_r, div_sh_r;
  logic [RES_W-1:0] t0_r, t1_r, qt_r;

  // Modular multiplier
  logic [RES_W-1:0] cand_r, addend_r, acc_r, mul_sh_r;
  logic             err_r;

  // Held inverse of key_a mod m
  logic [RES_W-1:0] inv_r;
  logic             inv_err_r, inv_ok_r;

  // Result register
  logic              out_valid_r;
  afc_pkg::afc_out_t out_data_r;

  // Combinational helpers
  logic [MOD_W-1:0] m_eff;
  logic             drop;
  logic             cnt_done;
  logic [MOD_W:0]   rem_ext, rem_sub;
  logic             q_bit;
  logic [MOD_W-1:0] rem_step;
  logic [RES_W-1:0] qt_step;
  logic [RES_W-1:0] mul_step;
  logic             in_xfer, out_load, cfg_xfer;

  // Clamp the modulus to the symbol range.
  always_comb begin
    if (afc_pkg::CMP_W'(alph_r) > afc_pkg::CMP_W'(afc_pkg::MOD_MAX)) begin
      m_eff = afc_pkg::MOD_MAX;
    end else begin
      m_eff = MOD_W'(alph_r);
    end
  end

  // Unknown character: drop it at the transfer.
  assign drop     = MOD_W'(in_data.symbol) >= m_eff;
  assign cnt_done = (cnt_r == '0);
  assign in_xfer  = in_valid && in_ready;
  assign cfg_xfer = cfg_valid && cfg_ready;

  // Restoring division step; quotient bits feed the q*t1 Horner sum.
  always_comb begin
    rem_ext  = {rem_r, div_sh_r[MOD_W-1]};
    rem_sub  = rem_ext - {1'b0, r1_r};
    q_bit    = (rem_ext >= {1'b0, r1_r});
    rem_step = q_bit ? rem_sub[MOD_W-1:0] : rem_ext[MOD_W-1:0];
    qt_step  = dbl_add(qt_r, q_bit ? t1_r : '0, m_eff);
    mul_step = dbl_add(acc_r, mul_sh_r[RES_W-1] ? cand_r : '0, m_eff);
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      afc_pkg::ST_IDLE: begin
        if (in_xfer && !drop) state_nxt = afc_pkg::ST_REDUCE;
      end
      afc_pkg::ST_REDUCE: begin
        if (cnt_done) state_nxt = afc_pkg::ST_ROUTE;
      end
      afc_pkg::ST_ROUTE: begin
        if (kind_r == afc_pkg::KIND_ENCRYPT) begin
          state_nxt = afc_pkg::ST_MUL;
        end else if (!inv_ok_r) begin
          state_nxt = afc_pkg::ST_EUC;
        end else if (inv_err_r) begin
          state_nxt = afc_pkg::ST_FIN;
        end else begin
          state_nxt = afc_pkg::ST_MUL;
        end
      end
      afc_pkg::ST_EUC: begin
        state_nxt = (r1_r == '0) ? afc_pkg::ST_ROUTE : afc_pkg::ST_DIV;
      end
      afc_pkg::ST_DIV: begin
        if (cnt_done) state_nxt = afc_pkg::ST_UPD;
      end
      afc_pkg::ST_UPD: begin
        state_nxt = afc_pkg::ST_EUC;
      end
      afc_pkg::ST_MUL: begin
        if (cnt_done) state_nxt = afc_pkg::ST_FIN;
      end
      afc_pkg::ST_FIN: begin
        if (!out_valid_r || out_ready) state_nxt = afc_pkg::ST_IDLE;
      end
      default: state_nxt = afc_pkg::ST_IDLE;
    endcase
  end

  // Handshake outputs; a pending configuration write goes first.
  always_comb begin
    in_ready  = (state_r == afc_pkg::ST_IDLE) && !cfg_valid;
    cfg_ready = (state_r == afc_pkg::ST_IDLE);
    out_load  = (state_r == afc_pkg::ST_FIN) && (!out_valid_r || out_ready);
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= afc_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
      inv_ok_r    <= 1'b0;
      key_a_r     <= KEY_W'(1);
      key_b_r     <= '0;
      alph_r      <= afc_pkg::ALPH_W'(26);
    end else begin
      state_r <= state_nxt;
      // Drop the result once taken; a new one may land in the same cycle.
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (state_r == afc_pkg::ST_EUC && r1_r == '0) inv_ok_r <= 1'b1;
      if (cfg_xfer) begin
        unique case (cfg_index)
          afc_pkg::REG_KEY_A: begin
            key_a_r  <= cfg_data[KEY_W-1:0];
            inv_ok_r <= 1'b0;
          end
          afc_pkg::REG_KEY_B: begin
            key_b_r <= cfg_data[KEY_W-1:0];
          end
          afc_pkg::REG_ALPHABET: begin
            alph_r   <= cfg_data;
            inv_ok_r <= 1'b0;
          end
          default: ;
        endcase
      end
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    unique case (state_r)
      afc_pkg::ST_IDLE: begin
        if (in_xfer) begin
          kind_r <= in_data.kind;
          x_r    <= in_data.symbol;
          a_sh_r <= key_a_r;
          b_sh_r <= key_b_r;
          ra_r   <= '0;
          rb_r   <= '0;
          cnt_r  <= CNT_W'(KEY_W - 1);
        end
      end
      afc_pkg::ST_REDUCE: begin
        // Reduce both keys mod m, one bit a cycle, MSB first.
        ra_r   <= red_step(ra_r, a_sh_r[KEY_W-1], m_eff);
        rb_r   <= red_step(rb_r, b_sh_r[KEY_W-1], m_eff);
        a_sh_r <= a_sh_r << 1;
        b_sh_r <= b_sh_r << 1;
        cnt_r  <= cnt_r - CNT_W'(1);
      end
      afc_pkg::ST_ROUTE: begin
        acc_r <= '0;
        err_r <= 1'b0;
        cnt_r <= CNT_W'(RES_W - 1);
        if (kind_r == afc_pkg::KIND_ENCRYPT) begin
          cand_r   <= ra_r[RES_W-1:0];
          mul_sh_r <= x_r;
          addend_r <= rb_r[RES_W-1:0];
        end else if (!inv_ok_r) begin
          // Start extended Euclid with t tracked mod m.
          r0_r <= m_eff;
          r1_r <= ra_r;
          t0_r <= '0;
          t1_r <= (m_eff == MOD_W'(1)) ? '0 : RES_W'(1);
        end else begin
          cand_r   <= inv_r;
          mul_sh_r <= sub_mod(x_r, rb_r[RES_W-1:0], m_eff);
          addend_r <= '0;
          err_r    <= inv_err_r;
        end
      end
      afc_pkg::ST_EUC: begin
        if (r1_r == '0) begin
          inv_r     <= t0_r;
          inv_err_r <= (r0_r != MOD_W'(1));
        end else begin
          div_sh_r <= r0_r;
          rem_r    <= '0;
          qt_r     <= '0;
          cnt_r    <= CNT_W'(MOD_W - 1);
        end
      end
      afc_pkg::ST_DIV: begin
        rem_r    <= rem_step;
        qt_r     <= qt_step;
        div_sh_r <= div_sh_r << 1;
        cnt_r    <= cnt_r - CNT_W'(1);
      end
      afc_pkg::ST_UPD: begin
        r0_r <= r1_r;
        r1_r <= rem_r;
        t0_r <= t1_r;
        t1_r <= sub_mod(t0_r, qt_r, m_eff);
      end
      afc_pkg::ST_MUL: begin
        acc_r    <= mul_step;
        mul_sh_r <= mul_sh_r << 1;
        cnt_r    <= cnt_r - CNT_W'(1);
      end
      afc_pkg::ST_FIN: begin
        if (out_load) begin
          out_data_r.coded_symbol <= err_r ? '0 : add_mod(acc_r, addend_r, m_eff);
          out_data_r.key_error    <= err_r;
        end
      end
      default: ;
    endcase
  end

  // A dropped symbol must leave the sequencer idle.
  a_drop_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (in_xfer && drop) |=> (state_r == afc_pkg::ST_IDLE))
    else $error("dropped symbol started the sequencer");

  // Euclid remainders shrink strictly.
  a_euc_order: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == afc_pkg::ST_EUC) |-> (r1_r < r0_r))
    else $error("Euclid remainder not below divisor");

  // Multiplier accumulator stays a residue.
  a_acc_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == afc_pkg::ST_MUL || state_r == afc_pkg::ST_FIN) |->
      (MOD_W'(acc_r) < m_eff))
    else $error("accumulator out of residue range");

  // A flagged result carries symbol zero.
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.key_error) |-> (out_data_r.coded_symbol == '0))
    else $error("key error with nonzero symbol");

endmodule
